// ===== rtl/i2crs_pkg.sv =====
// Shared types and codes for the I2C register access sequencer.
package i2crs_pkg;

    // Bus event codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_BEGIN      = 3'd0,
        CMD_START_SENT = 3'd1,
        CMD_ADDR_ACKED = 3'd2,
        CMD_TX_EMPTY   = 3'd3,
        CMD_RX_BYTE    = 3'd4,
        CMD_NACK       = 3'd5,
        CMD_ARB_LOST   = 3'd6
    } cmd_t;

    // Transfer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TX   = 2'd1,
        PH_RX   = 2'd2
    } phase_t;

    // Transfer status reported with every result
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_BUSY = 3'd1,
        ST_DONE = 3'd2,
        ST_NACK = 3'd3,
        ST_ARLO = 3'd4
    } status_t;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Input beat payload, first field in the highest bits
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        read_not_write;
        logic [15:0] length;
        logic [7:0]  register_address;
        logic [6:0]  device_address;
    } in_data_t;

    // One input item: event code plus payload
    typedef struct packed {
        logic [2:0] command;
        in_data_t   data;
    } in_item_t;

    // Result beat payload, first field in the highest bits
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] store_index;
        logic [7:0]  store_value;
        logic        store_valid;
        logic        enable_ack;
        logic        issue_stop;
        logic        issue_start;
        logic [7:0]  send_value;
        logic        send_valid;
    } result_t;

endpackage

// ===== rtl/i2crs_in_reg.sv =====
// Input register stage: captures one event beat and holds it until the engine takes it.
module i2crs_in_reg
    import i2crs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept a new beat whenever the slot is empty or drains this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== rtl/i2crs_engine.sv =====
// Transfer state registers and the per-event next-state and result logic.
module i2crs_engine
    import i2crs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_item_t item,
    output result_t  result
);

    phase_t      phase_reg,       phase_next;
    logic        dir_read_reg,    dir_read_next;
    logic [6:0]  target_addr_reg, target_addr_next;
    logic [7:0]  target_reg_reg,  target_reg_next;
    logic [15:0] length_reg,      length_next;
    logic [15:0] position_reg,    position_next;
    status_t     status_reg,      status_next;

    logic [15:0] position_inc;
    logic        last_byte;
    cmd_t        cmd;

    assign cmd          = cmd_t'(item.command);
    assign position_inc = position_reg + 16'd1;
    assign last_byte    = (position_inc == length_reg);

    // Next state and result for one event
    always_comb
    begin
        phase_next       = phase_reg;
        dir_read_next    = dir_read_reg;
        target_addr_next = target_addr_reg;
        target_reg_next  = target_reg_reg;
        length_next      = length_reg;
        position_next    = position_reg;
        status_next      = status_reg;
        result           = '0;

        if (cmd == CMD_BEGIN)
        begin
            target_addr_next = item.data.device_address;
            target_reg_next  = item.data.register_address;
            length_next      = item.data.length;
            dir_read_next    = item.data.read_not_write;
            position_next    = '0;
            if (item.data.length == 16'd0)
            begin
                status_next = ST_DONE;
                phase_next  = PH_IDLE;
            end
            else
            begin
                status_next        = ST_BUSY;
                phase_next         = PH_TX;
                result.issue_start = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (cmd == CMD_NACK)
            begin
                result.issue_stop = 1'b1;
                status_next       = ST_NACK;
                phase_next        = PH_IDLE;
            end
            else if (cmd == CMD_ARB_LOST)
            begin
                status_next = ST_ARLO;
                phase_next  = PH_IDLE;
            end
            else if (phase_reg == PH_TX)
            begin
                case (cmd)
                    CMD_START_SENT:
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = {target_addr_reg, 1'b0};
                    end
                    CMD_ADDR_ACKED:
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = target_reg_reg;
                        if (dir_read_reg)
                        begin
                            result.issue_start = 1'b1;
                            phase_next         = PH_RX;
                        end
                    end
                    CMD_TX_EMPTY:
                    begin
                        if (!dir_read_reg)
                        begin
                            result.send_valid  = 1'b1;
                            result.send_value  = item.data.data_byte;
                            result.store_index = position_reg;
                            position_next      = position_inc;
                            if (last_byte)
                            begin
                                result.issue_stop = 1'b1;
                                status_next       = ST_DONE;
                                phase_next        = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (cmd)
                    CMD_START_SENT:
                    begin
                        result.send_valid = 1'b1;
                        result.send_value = {target_addr_reg, 1'b1};
                        result.enable_ack = (length_reg > 16'd1);
                    end
                    CMD_RX_BYTE:
                    begin
                        result.store_valid = 1'b1;
                        result.store_value = item.data.data_byte;
                        result.store_index = position_reg;
                        position_next      = position_inc;
                        if (last_byte)
                        begin
                            result.issue_stop = 1'b1;
                            status_next       = ST_DONE;
                            phase_next        = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        result.status = status_next;
    end

    // Commit state only when the event moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            dir_read_reg    <= 1'b0;
            target_addr_reg <= '0;
            target_reg_reg  <= '0;
            length_reg      <= '0;
            position_reg    <= '0;
            status_reg      <= ST_IDLE;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            dir_read_reg    <= dir_read_next;
            target_addr_reg <= target_addr_next;
            target_reg_reg  <= target_reg_next;
            length_reg      <= length_next;
            position_reg    <= position_next;
            status_reg      <= status_next;
        end
    end

endmodule

// ===== rtl/i2crs_out_reg.sv =====
// Result register: holds one result beat until the downstream side takes it.
module i2crs_out_reg
    import i2crs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/i2c_master_register_access_sequencer_core.sv =====
// Top level of the I2C master register access sequencer.
//
//  channel  | dir | tdata                            | tuser
//  ---------+-----+----------------------------------+------------------
//  s_axis   | in  | 40 bits, event payload           | 3-bit event code
//  m_axis   | out | 40 bits, one result per event    | none
//
// Each event beat is registered in the input stage, evaluated against the transfer state and
// written to the result register; one event per cycle is sustained while m_axis is not
// stalled.
// rst_n clears both stage valids and returns the transfer to idle.
// A stall on m_axis holds the result; the input stage keeps taking one more
// beat, then back-pressure reaches s_axis_tready.
module i2c_master_register_access_sequencer_core
    import i2crs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // device_address[6:0], register_address[14:7], length[30:15],
    // read_not_write[31], data_byte[39:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // send_valid[0], send_value[8:1], issue_start[9], issue_stop[10],
    // enable_ack[11], store_valid[12], store_value[20:13],
    // store_index[36:21], status[39:37]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     out_free;
    logic     advance;
    result_t  step_result;
    result_t  out_result;

    assign in_item.command = s_axis_tuser;
    assign in_item.data    = in_data_t'(s_axis_tdata);

    // Move an event into the result register when there is room
    assign advance = held_valid && out_free;

    i2crs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    i2crs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (held_item),
        .result (step_result)
    );

    i2crs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_data (step_result),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = OUT_DATA_W'(out_result);

endmodule

// ===== rtl/i2crs_checker.sv =====
// Port-level checks for the sequencer core, bound to the top level.
module i2crs_checker
    import i2crs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Never send and store in one event
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[12]))
        else $error("send and store in the same result");

    // Never request start and stop together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
        else $error("start and stop requested together");

    // Status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:37] <= ST_ARLO))
        else $error("status code out of range");

endmodule

bind i2c_master_register_access_sequencer_core i2crs_checker u_i2crs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/i2crs_action_checker.sv =====
// Checker for the I2C register access sequencer: predicts and compares every result beat.
module i2crs_action_checker
    import i2crs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [2:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the transfer state
    phase_t      cur_phase;
    logic        read_dir;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] xfer_len;
    logic [15:0] byte_pos;
    status_t     xfer_status;

    result_t     awaited_actions[$];
    int          err_total;

    // Step past one data byte; true when it was the last one
    function automatic bit advance_position();
        byte_pos = byte_pos + 16'd1;
        if (byte_pos == xfer_len)
        begin
            xfer_status = ST_DONE;
            cur_phase   = PH_IDLE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Bus actions caused by one event, updating the shadow state
    function automatic result_t predict_actions(input logic [2:0] ev, input in_data_t d);
        result_t r;
        r = '0;
        if (ev == CMD_BEGIN)
        begin
            dev_addr = d.device_address;
            reg_addr = d.register_address;
            xfer_len = d.length;
            read_dir = d.read_not_write;
            byte_pos = '0;
            if (d.length == 16'd0)
            begin
                xfer_status = ST_DONE;
                cur_phase   = PH_IDLE;
            end
            else
            begin
                xfer_status   = ST_BUSY;
                cur_phase     = PH_TX;
                r.issue_start = 1'b1;
            end
        end
        else if (cur_phase != PH_IDLE)
        begin
            if (ev == CMD_NACK)
            begin
                r.issue_stop = 1'b1;
                xfer_status  = ST_NACK;
                cur_phase    = PH_IDLE;
            end
            else if (ev == CMD_ARB_LOST)
            begin
                xfer_status = ST_ARLO;
                cur_phase   = PH_IDLE;
            end
            else if (cur_phase == PH_TX)
            begin
                // header and write data
                if (ev == CMD_START_SENT)
                begin
                    r.send_valid = 1'b1;
                    r.send_value = {dev_addr, 1'b0};
                end
                else if (ev == CMD_ADDR_ACKED)
                begin
                    r.send_valid = 1'b1;
                    r.send_value = reg_addr;
                    if (read_dir)
                    begin
                        r.issue_start = 1'b1;
                        cur_phase     = PH_RX;
                    end
                end
                else if (ev == CMD_TX_EMPTY && !read_dir)
                begin
                    r.send_valid  = 1'b1;
                    r.send_value  = d.data_byte;
                    r.store_index = byte_pos;
                    r.issue_stop  = advance_position();
                end
            end
            else
            begin
                // read address and received bytes
                if (ev == CMD_START_SENT)
                begin
                    r.send_valid = 1'b1;
                    r.send_value = {dev_addr, 1'b1};
                    r.enable_ack = (xfer_len > 16'd1);
                end
                else if (ev == CMD_RX_BYTE)
                begin
                    r.store_valid = 1'b1;
                    r.store_value = d.data_byte;
                    r.store_index = byte_pos;
                    r.issue_stop  = advance_position();
                end
            end
        end
        r.status = xfer_status;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            err_total++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Track input beats, compare result beats against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            cur_phase   = PH_IDLE;
            read_dir    = 1'b0;
            dev_addr    = '0;
            reg_addr    = '0;
            xfer_len    = '0;
            byte_pos    = '0;
            xfer_status = ST_IDLE;
            awaited_actions.delete();
            err_total   = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_actions.push_back(predict_actions(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (awaited_actions.size() == 0)
                begin
                    err_total++;
                    $display("%0t ns: result beat with nothing expected, actual 0x%0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = awaited_actions.pop_front();
                    check_field("send_valid",  want.send_valid,  got.send_valid);
                    check_field("send_value",  want.send_value,  got.send_value);
                    check_field("issue_start", want.issue_start, got.issue_start);
                    check_field("issue_stop",  want.issue_stop,  got.issue_stop);
                    check_field("enable_ack",  want.enable_ack,  got.enable_ack);
                    check_field("store_valid", want.store_valid, got.store_valid);
                    check_field("store_value", want.store_value, got.store_value);
                    check_field("store_index", want.store_index, got.store_index);
                    check_field("status",      want.status,      got.status);
                end
            end
            fail_count    <= err_total;
            pending_count <= awaited_actions.size();
        end
    end

endmodule

// ===== tb/tb_i2c_master_register_access_sequencer_core.sv =====
// Testbench top: drives bus events into the sequencer and gives the verdict.
module tb_i2c_master_register_access_sequencer_core;
    import i2crs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         ITEM_TARGET = 1650;
    localparam int         CYCLE_LIMIT = 1000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_count;
    int beats_sent = 0;
    int cycle_count = 0;
    bit tx_idle_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int hold_left = 0;

    i2c_master_register_access_sequencer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2crs_action_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** i2c_master_register_access_sequencer_core: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 75)
            return $urandom_range(3, 1);
        if (p < 95)
            return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    // Result sink: ready with random stall stretches, sometimes none at all
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_stall_on && $urandom_range(99) < 20)
                hold_left <= pick_gap();
        end
        if ($urandom_range(199) == 0)
            rx_stall_on <= !rx_stall_on;
    end

    function automatic in_data_t random_payload();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[IN_DATA_W-1:0];
    endfunction

    // Present one beat, hold until taken, then maybe idle
    task automatic send_event(input logic [2:0] ev, input in_data_t d);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_bus_event(input logic [2:0] ev, input logic [7:0] byte_val);
        in_data_t d;
        d = random_payload();
        d.data_byte = byte_val;
        send_event(ev, d);
    endtask

    task automatic send_begin(input logic [6:0] dev, input logic [7:0] regn,
                              input logic [15:0] len, input logic rd);
        in_data_t d;
        d = random_payload();
        d.device_address   = dev;
        d.register_address = regn;
        d.length           = len;
        d.read_not_write   = rd;
        send_event(CMD_BEGIN, d);
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // One step of a transfer, sometimes preceded by noise or replaced by a fault
    task automatic transfer_step(input logic [2:0] ev, output bit ended);
        int p;
        p = $urandom_range(99);
        ended = 1'b0;
        if (p < 4)
            send_event(3'($urandom_range(7, 0)), random_payload());
        if (p >= 98)
        begin
            send_bus_event(p[0] ? CMD_NACK : CMD_ARB_LOST, 8'($urandom));
            ended = 1'b1;
        end
        else
            send_bus_event(ev, 8'($urandom));
    endtask

    // A well-formed register write or read with random content
    task automatic run_transfer();
        in_data_t d;
        int p;
        int len;
        bit ended;
        d = random_payload();
        p = $urandom_range(99);
        if (p < 80)
            d.length = 16'($urandom_range(6, 1));
        else if (p < 95)
            d.length = 16'($urandom_range(40, 7));
        len = d.length;
        send_event(CMD_BEGIN, d);
        if (len == 0)
            return;
        transfer_step(CMD_START_SENT, ended);
        if (ended)
            return;
        transfer_step(CMD_ADDR_ACKED, ended);
        if (ended)
            return;
        if (d.read_not_write)
        begin
            transfer_step(CMD_START_SENT, ended);
            if (ended)
                return;
            if ($urandom_range(1))
            begin
                transfer_step(CMD_ADDR_ACKED, ended);
                if (ended)
                    return;
            end
        end
        // long transfers are cut short and left for the next begin to replace
        for (int i = 0; i < len && i < 64; i++)
        begin
            transfer_step(d.read_not_write ? CMD_RX_BYTE : CMD_TX_EMPTY, ended);
            if (ended)
                return;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // events while idle are ignored
        send_bus_event(CMD_START_SENT, 8'h12);
        send_bus_event(CMD_TX_EMPTY, 8'h34);
        send_bus_event(CMD_UNUSED, 8'h56);
        // zero length completes at once
        send_begin(7'h7F, 8'hFF, 16'd0, 1'b0);
        // two-byte write, stray rx byte ignored in the header phase
        send_begin(7'h7F, 8'hFF, 16'd2, 1'b0);
        send_bus_event(CMD_START_SENT, 8'h00);
        send_bus_event(CMD_ADDR_ACKED, 8'h00);
        send_bus_event(CMD_RX_BYTE, 8'h77);
        send_bus_event(CMD_TX_EMPTY, 8'hFF);
        send_bus_event(CMD_TX_EMPTY, 8'h00);
        // one-byte read, address ack in receive phase stores nothing
        send_begin(7'h00, 8'h00, 16'd1, 1'b1);
        send_bus_event(CMD_START_SENT, 8'hFF);
        send_bus_event(CMD_ADDR_ACKED, 8'hFF);
        send_bus_event(CMD_START_SENT, 8'hFF);
        send_bus_event(CMD_ADDR_ACKED, 8'hFF);
        send_bus_event(CMD_RX_BYTE, 8'hA5);
        // longest read, ack enabled, ended by nack
        send_begin(7'h55, 8'hAA, 16'hFFFF, 1'b1);
        send_bus_event(CMD_START_SENT, 8'h00);
        send_bus_event(CMD_ADDR_ACKED, 8'h00);
        send_bus_event(CMD_START_SENT, 8'h00);
        send_bus_event(CMD_RX_BYTE, 8'h5A);
        send_bus_event(CMD_NACK, 8'h00);
        // begin while busy replaces the transfer, then arbitration is lost
        send_begin(7'h2A, 8'h3C, 16'd3, 1'b0);
        send_begin(7'h11, 8'h22, 16'd4, 1'b1);
        send_bus_event(CMD_START_SENT, 8'h00);
        send_bus_event(CMD_ARB_LOST, 8'h00);
        drain_results();

        while (beats_sent < ITEM_TARGET)
        begin
            if ($urandom_range(9) == 0)
                tx_idle_on = !tx_idle_on;
            if ($urandom_range(19) == 0)
                drain_results();
            run_transfer();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("** i2c_master_register_access_sequencer_core: PASSED **");
        else
            $display("** i2c_master_register_access_sequencer_core: FAILED **");
        $finish;
    end

endmodule
